// File: sv/mec_pkg.sv
package mec_pkg;

  // Datapath format: signed fixed point, DataWidth bits with FracBits fraction bits.
  localparam int DataWidth  = 32;
  localparam int FracBits   = 28;
  localparam int InWidth    = 32;
  localparam int CountWidth = 16;
  localparam int IterWidth  = CountWidth + 1;
  localparam int ProdWidth  = 2 * DataWidth;
  localparam int SumWidth   = ProdWidth + 2;
  localparam int ExtWidth   = (DataWidth > InWidth) ? DataWidth : InWidth;

  localparam logic [CountWidth-1:0] LimitReset     = CountWidth'(10000);
  localparam int                    EscapeRadiusSq = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic load;     // take a new point, clear z and the count
    logic step;     // write the next z and the incremented count
    logic finish;   // capture the result into the output register
    logic escaped;  // result is the count rather than zero
  } dp_cmd_t;

  typedef struct packed {
    logic escape;   // |z|^2 of the current z exceeds the squared radius
    logic zero;     // next z is exactly zero
    logic limit;    // next count exceeds the iteration limit
  } dp_status_t;

endpackage

// File: sv/mandelbrot_escape_count.sv
// Channel   Handshake               Payload
// input     in_valid_i/in_ready_o   c_real_i, c_imag_i (signed Q4.28)
// output    out_valid_o/out_ready_i escape_count_o (16 bit, 0 = inside)
// config    cfg_we_i                cfg_data_i (max_iterations, reset 10000)
//
// Each iteration of z = z^2 + c has a multiply step, for the three 32x32
// multipliers, and then a step for the add, round, saturate and the exit tests.
// The limit stops a point at iteration N = max_iterations + 1, and the block
// returns to idle, ready for the next point, as the result is written.
// A new point is taken as soon as the block is idle, even while the previous
// result still waits; a finished point holds in its last step until the output
// register is free. Reset restores the limit to 10000 and empties the block.
module mandelbrot_escape_count import mec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CountWidth-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [31:0]    c_real_i,
  input  logic signed [31:0]    c_imag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CountWidth-1:0] escape_count_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mec_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .c_real_i       (c_real_i),
    .c_imag_i       (c_imag_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .escape_count_o (escape_count_o)
  );

endmodule

// File: sv/mec_datapath.sv
module mec_datapath import mec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CountWidth-1:0] cfg_data_i,
  input  logic signed [31:0]    c_real_i,
  input  logic signed [31:0]    c_imag_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic [CountWidth-1:0] escape_count_o
);

  localparam logic signed [DataWidth-1:0] ZMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] ZMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [ProdWidth:0] EscThr =
    (ProdWidth+1)'(EscapeRadiusSq) << (2 * FracBits);

  function automatic logic signed [DataWidth-1:0] sat_sum(
    input logic signed [SumWidth-1:0] v
  );
    logic signed [DataWidth-1:0] r;
    if (v > SumWidth'(ZMax)) begin
      r = ZMax;
    end else if (v < SumWidth'(ZMin)) begin
      r = ZMin;
    end else begin
      r = v[DataWidth-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataWidth-1:0] sat_ext(
    input logic signed [ExtWidth-1:0] v
  );
    logic signed [DataWidth-1:0] r;
    if (v > ExtWidth'(ZMax)) begin
      r = ZMax;
    end else if (v < ExtWidth'(ZMin)) begin
      r = ZMin;
    end else begin
      r = v[DataWidth-1:0];
    end
    return r;
  endfunction

  logic [CountWidth-1:0]        max_iter_q;
  logic signed [DataWidth-1:0]  pr_q, pi_q;
  logic signed [DataWidth-1:0]  zr_q, zi_q, zr_d, zi_d;
  logic [IterWidth-1:0]         count_q, count_d;
  logic signed [ProdWidth-1:0]  rr_q, ii_q, ri_q;
  logic signed [SumWidth-1:0]   nr, ni, nr_sh, ni_sh;
  logic [ProdWidth:0]           mag;
  logic [CountWidth-1:0]        result_q;

  // Products are refreshed every cycle; z only moves on a load or a step, so
  // they are valid in the cycle after any update.
  always_ff @(posedge clk_i) begin
    rr_q <= zr_q * zr_q;
    ii_q <= zi_q * zi_q;
    ri_q <= zr_q * zi_q;
  end

  always_comb begin
    nr    = SumWidth'(rr_q) - SumWidth'(ii_q) + (SumWidth'(pr_q) <<< FracBits);
    ni    = SumWidth'(ri_q) + (SumWidth'(pi_q) <<< (FracBits - 1));
    nr_sh = nr >>> FracBits;
    ni_sh = ni >>> (FracBits - 1);
    zr_d  = sat_sum(nr_sh);
    zi_d  = sat_sum(ni_sh);
    count_d = count_q + IterWidth'(1);
    // The squares of the current z double as the escape magnitude.
    mag   = {1'b0, rr_q[ProdWidth-1:0]} + {1'b0, ii_q[ProdWidth-1:0]};
  end

  assign status_o.escape = (mag > EscThr);
  assign status_o.zero   = (zr_d == '0) && (zi_d == '0);
  assign status_o.limit  = (count_d > {1'b0, max_iter_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= LimitReset;
      zr_q       <= '0;
      zi_q       <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_iter_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        zr_q    <= '0;
        zi_q    <= '0;
        count_q <= '0;
      end else if (cmd_i.step) begin
        zr_q    <= zr_d;
        zi_q    <= zi_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pr_q <= sat_ext(ExtWidth'(c_real_i));
      pi_q <= sat_ext(ExtWidth'(c_imag_i));
    end
    if (cmd_i.finish) begin
      result_q <= cmd_i.escaped ? count_q[CountWidth-1:0] : '0;
    end
  end

  assign escape_count_o = result_q;

endmodule

// File: sv/mec_ctrl.sv
module mec_ctrl import mec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.escape || status_i.zero || status_i.limit) begin
          // Hold here until the output register can take the result.
          if (slot_free) begin
            cmd_o.finish  = 1'b1;
            cmd_o.escaped = status_i.escape;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_mul_then_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_STEP)
    else $error("multiply cycle not followed by step cycle");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> state_q == ST_STEP && !cmd_o.step && !cmd_o.load)
    else $error("result captured outside the step cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !out_valid_q || out_ready_i)
    else $error("pending result overwritten");

  a_escape_only_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.escaped |-> cmd_o.finish && status_i.escape)
    else $error("escape flag without a finishing escape");

endmodule

// File: bench/tb_mandelbrot_escape_count.sv
module tb_mandelbrot_escape_count;
  import mec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LimitCycles = 3_000_000;
  localparam int unsigned HoldCycles  = 600;

  localparam logic signed [InWidth-1:0] MaxC  = {1'b0, {(InWidth-1){1'b1}}};
  localparam logic signed [InWidth-1:0] MinC  = {1'b1, {(InWidth-1){1'b0}}};
  localparam logic signed [InWidth-1:0] OneC  = InWidth'(1) <<< FracBits;
  localparam logic signed [InWidth-1:0] TwoC  = InWidth'(2) <<< FracBits;

  localparam logic signed [SumWidth-1:0] ZMax = (SumWidth'(1) <<< (DataWidth-1)) - 1;
  localparam logic signed [SumWidth-1:0] ZMin = -ZMax - 1;

  typedef struct packed {
    logic signed [InWidth-1:0] re;
    logic signed [InWidth-1:0] im;
  } c_point_t;

  typedef struct {
    logic signed [InWidth-1:0] re;
    logic signed [InWidth-1:0] im;
    logic [CountWidth-1:0]     count;
  } count_due_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CountWidth-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic signed [31:0]    c_real_i = '0;
  logic signed [31:0]    c_imag_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CountWidth-1:0] escape_count_o;

  c_point_t   point_queue[$];
  count_due_t expected_counts[$];

  logic [CountWidth-1:0] iter_limit = LimitReset;
  int unsigned points_queued = 0;
  int unsigned points_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned limits_written = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic        in_took = 1'b0;
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  logic        long_hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  logic [1:0]  stall_mode = 2'd0;
  logic [7:0]  rx_tick = '0;

  mandelbrot_escape_count DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .c_real_i      (c_real_i),
    .c_imag_i      (c_imag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .escape_count_o(escape_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [DataWidth-1:0] saturate(input logic signed [SumWidth-1:0] v);
    if (v > ZMax) begin
      return ZMax[DataWidth-1:0];
    end else if (v < ZMin) begin
      return ZMin[DataWidth-1:0];
    end
    return v[DataWidth-1:0];
  endfunction

  // Iterates z = z^2 + c from zero with floor rounding and saturation of z, and
  // returns the escape iteration, or zero for points taken as inside the set.
  function automatic logic [CountWidth-1:0] escape_time(input logic signed [InWidth-1:0] re,
                                                        input logic signed [InWidth-1:0] im,
                                                        input logic [CountWidth-1:0] limit);
    logic signed [SumWidth-1:0]  c_re, c_im, zr_w, zi_w, next_re, next_im, radius;
    logic signed [DataWidth-1:0] zr, zi;
    logic [CountWidth-1:0]       verdict;
    int unsigned                 count;
    logic                        done;
    c_re = saturate(re);
    c_im = saturate(im);
    radius = SumWidth'(EscapeRadiusSq) <<< (2 * FracBits);
    zr = '0;
    zi = '0;
    count = 0;
    verdict = '0;
    done = 1'b0;
    while (!done) begin
      zr_w = zr;
      zi_w = zi;
      next_re = (zr_w * zr_w - zi_w * zi_w + (c_re <<< FracBits)) >>> FracBits;
      next_im = (zr_w * zi_w + (c_im <<< (FracBits - 1))) >>> (FracBits - 1);
      zr = saturate(next_re);
      zi = saturate(next_im);
      count++;
      zr_w = zr;
      zi_w = zi;
      if (zr == '0 && zi == '0) begin
        done = 1'b1;
      end else if (count > limit) begin
        done = 1'b1;
      end else if (zr_w * zr_w + zi_w * zi_w > radius) begin
        verdict = CountWidth'(count);
        done = 1'b1;
      end
    end
    return verdict;
  endfunction

  // Sender: bursts of points separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // Point still waiting for its transfer; hold it.
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (point_queue.size() != 0) begin
      c_real_i <= point_queue[0].re;
      c_imag_i <= point_queue[0].im;
      void'(point_queue.pop_front());
      in_valid_i <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: randomly chosen stall patterns, each held for a random span, plus one long
  // hold-off once enough points are queued so that the block backs up.
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && results_seen >= 50 &&
                 points_queued >= points_accepted + 4) begin
      long_hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= 1'($urandom_range(0, 1));
        2'd2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (rx_tick[1:0] == 2'd0);
      endcase
    end
  end

  // Results are checked before the new point is predicted, so a point taken in
  // the same cycle can never be matched against this result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          $error("escape_count %0d arrived with no point outstanding", escape_count_o);
          error_count++;
        end else begin
          if (escape_count_o !== expected_counts[0].count) begin
            $error("escape_count mismatch for c = (%0d, %0d): expected %0d, actual %0d",
                   expected_counts[0].re, expected_counts[0].im,
                   expected_counts[0].count, escape_count_o);
            error_count++;
          end
          void'(expected_counts.pop_front());
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid_i && in_ready_o) begin
        expected_counts.push_back('{c_real_i, c_imag_i,
                                    escape_time(c_real_i, c_imag_i, iter_limit)});
        points_accepted <= points_accepted + 1;
      end
    end
    in_took <= rst_ni && in_valid_i && in_ready_o;
  end

  initial begin
    while (cycle_count < LimitCycles) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, expected_counts.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (points_accepted != points_queued || expected_counts.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [CountWidth-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    iter_limit = value;
    limits_written++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer(input logic signed [InWidth-1:0] re, input logic signed [InWidth-1:0] im);
    point_queue.push_back('{re, im});
    points_queued++;
  endtask

  // Mostly points near the set, where orbits are long and the rounding matters,
  // with full-range patterns to toggle every bit.
  task automatic offer_random(input int unsigned n);
    logic signed [InWidth-1:0] re, im;
    int unsigned k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          re = -(5 <<< (FracBits - 1)) + $urandom_range(0, 7 <<< (FracBits - 1));
          im = -(3 <<< (FracBits - 1)) + $urandom_range(0, 6 <<< (FracBits - 1));
        end
        4, 5: begin
          re = $urandom_range(0, 2047) - 1024;
          im = $urandom_range(0, 2047) - 1024;
        end
        6, 7, 8: begin
          re = $urandom;
          im = $urandom;
        end
        default: begin
          re = $urandom_range(0, 1) ? MaxC : MinC;
          im = $urandom_range(0, 1) ? TwoC : -TwoC;
        end
      endcase
      offer(re, im);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default limit: extremes of c, an orbit that hits zero, escape exactly on
    // the radius, and a point held at |z| = 2 until the limit runs out.
    offer('0, '0);
    offer(MaxC, MaxC);
    offer(MinC, MinC);
    offer(MinC, '0);
    offer(MaxC, MinC);
    offer('0, MinC);
    offer(TwoC, '0);
    offer('0, TwoC);
    offer(-OneC, '0);
    offer(OneC, '0);
    offer(-TwoC, '0);

    // A limit of zero is exceeded by the first iteration.
    set_limit('0);
    offer('0, '0);
    offer(MaxC, MaxC);
    offer(-TwoC, '0);
    offer(1, -1);

    set_limit(CountWidth'(1));
    offer(TwoC, '0);
    offer(MaxC, '0);
    offer(1, -1);
    offer(-1, -1);
    offer(-OneC, '0);

    // At the top limit the count has to run past the 16-bit range.
    set_limit('1);
    offer(-TwoC, '0);
    offer('0, TwoC);

    set_limit(CountWidth'($urandom_range(2, 30)));
    offer_random(25);
    set_limit(CountWidth'($urandom_range(30, 250)));
    offer_random(25);
    set_limit(CountWidth'($urandom_range(250, 1200)));
    offer_random(25);
    set_limit(CountWidth'($urandom_range(1, 12)));
    offer_random(25);

    wait_idle();
    repeat (50) @(negedge clk_i);

    $display("Checked %0d escape counts from %0d points under %0d iteration limits,",
             results_seen, points_accepted, limits_written + 1);
    $display("including 0, 1, 65535 and the reset value; long output hold-off taken: %0d.",
             long_hold_done);
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: mandelbrot_escape_count.f
sv/mec_pkg.sv
sv/mec_datapath.sv
sv/mec_ctrl.sv
sv/mandelbrot_escape_count.sv
bench/tb_mandelbrot_escape_count.sv
